// ===== rtl/jarc_pkg.sv =====
// Shared types and constants for the joystick axis auto-range classifier.
package jarc_pkg;

    // Fixed field widths
    localparam int AXIS_IDX_W = 4;
    localparam int RAW_W      = 16;
    localparam int ANGLE_W    = 16;

    // Stream widths; tdata padded to whole bytes, tuser left at the axis index width
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int S_TUSER_W  = AXIS_IDX_W;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_CAL_AXES = 6;
    localparam int DEF_POS_WIDTH    = 16;

    // Axis map
    localparam logic [AXIS_IDX_W-1:0] NUM_AXES           = 4'd8;
    localparam logic [AXIS_IDX_W-1:0] HAT_VERTICAL_INDEX = 4'd7;

    // Hat angle bounds in hundredths of a degree (whole-degree limits * 100, upper + 99)
    localparam logic [ANGLE_W-1:0] ANGLE_WRAP  = 16'd36000;
    localparam logic [ANGLE_W-1:0] HX_HIGH_MIN = 16'd1900;
    localparam logic [ANGLE_W-1:0] HX_HIGH_MAX = 16'd16199;
    localparam logic [ANGLE_W-1:0] HX_LOW_MIN  = 16'd19800;
    localparam logic [ANGLE_W-1:0] HX_LOW_MAX  = 16'd34299;
    localparam logic [ANGLE_W-1:0] HY_HIGH_MIN = 16'd10900;
    localparam logic [ANGLE_W-1:0] HY_HIGH_MAX = 16'd25199;
    localparam logic [ANGLE_W-1:0] HY_LOW_TOP  = 16'd7299;
    localparam logic [ANGLE_W-1:0] HY_LOW_BOT  = 16'd28800;

    typedef enum logic [1:0] {
        DIR_LOW  = 2'd0,
        DIR_MID  = 2'd1,
        DIR_HIGH = 2'd2
    } dir_t;

    // Control from the pipeline to the range tracker
    typedef struct packed {
        logic                  update;
        logic                  is_cal;
        logic [AXIS_IDX_W-1:0] axis_index;
    } trk_ctrl_t;

endpackage

// ===== rtl/jarc_hat_cls.sv =====
// POV hat direction decode from hat angle.
module jarc_hat_cls
    import jarc_pkg::*;
(
    input  logic               vertical,
    input  logic               hat_centered,
    input  logic [ANGLE_W-1:0] hat_angle,
    output dir_t               direction
);

    logic [ANGLE_W-1:0] angle_wrapped;
    logic               x_high, x_low, y_high, y_low;

    // Input never reaches twice the wrap, so one subtract is enough
    assign angle_wrapped = (hat_angle >= ANGLE_WRAP) ? hat_angle - ANGLE_WRAP : hat_angle;

    assign x_high = (angle_wrapped >= HX_HIGH_MIN) && (angle_wrapped <= HX_HIGH_MAX);
    assign x_low  = (angle_wrapped >= HX_LOW_MIN)  && (angle_wrapped <= HX_LOW_MAX);
    assign y_high = (angle_wrapped >= HY_HIGH_MIN) && (angle_wrapped <= HY_HIGH_MAX);
    assign y_low  = (angle_wrapped <= HY_LOW_TOP)  || (angle_wrapped >= HY_LOW_BOT);

    always_comb begin
        direction = DIR_MID;
        if (!hat_centered) begin
            if (vertical) begin
                if (y_high)     direction = DIR_HIGH;
                else if (y_low) direction = DIR_LOW;
            end else begin
                if (x_high)     direction = DIR_HIGH;
                else if (x_low) direction = DIR_LOW;
            end
        end
    end

endmodule

// ===== rtl/jarc_range_trk.sv =====
// Per-axis running min/max store and analog direction compare.
module jarc_range_trk
    import jarc_pkg::*;
#(
    parameter int NUM_CAL_AXES = DEF_NUM_CAL_AXES,
    parameter int POS_WIDTH    = DEF_POS_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  trk_ctrl_t            ctrl,
    input  logic [POS_WIDTH-1:0] pos,
    output dir_t                 direction
);

    localparam int CAL_IW = (NUM_CAL_AXES > 1) ? $clog2(NUM_CAL_AXES) : 1;

    logic [POS_WIDTH-1:0] min_reg [NUM_CAL_AXES];
    logic [POS_WIDTH-1:0] max_reg [NUM_CAL_AXES];
    logic [NUM_CAL_AXES-1:0] seeded_reg;

    logic [CAL_IW-1:0]    idx;
    logic                 seeded;
    logic [POS_WIDTH-1:0] min_next, max_next, center, spread, k_lo, k_hi;
    logic [POS_WIDTH:0]   sum;
    logic [POS_WIDTH+1:0] tri_lo, tri_hi;
    logic                 below, above;

    assign idx    = ctrl.axis_index[CAL_IW-1:0];
    assign seeded = ctrl.is_cal && seeded_reg[idx];

    // Widened bounds; first sample seeds both
    assign min_next = (seeded && (pos >= min_reg[idx])) ? min_reg[idx] : pos;
    assign max_next = (seeded && (pos <= max_reg[idx])) ? max_reg[idx] : pos;

    assign sum    = {1'b0, min_next} + {1'b0, max_next};
    assign center = sum[POS_WIDTH:1];
    assign spread = max_next - center;

    // pos < center - spread/3  <=>  spread < 3*(center - pos), likewise above
    assign k_lo   = center - pos;
    assign k_hi   = pos - center;
    assign tri_lo = {2'b00, k_lo} + {1'b0, k_lo, 1'b0};
    assign tri_hi = {2'b00, k_hi} + {1'b0, k_hi, 1'b0};
    assign below  = (pos < center) && ({2'b00, spread} < tri_lo);
    assign above  = (pos > center) && ({2'b00, spread} < tri_hi);

    always_comb begin
        direction = DIR_MID;
        if (seeded) begin
            if (below)      direction = DIR_LOW;
            else if (above) direction = DIR_HIGH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= '0;
        end else if (ctrl.update && ctrl.is_cal) begin
            seeded_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.update && ctrl.is_cal) begin
            min_reg[idx] <= min_next;
            max_reg[idx] <= max_next;
        end
    end

    a_seed_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.update && ctrl.is_cal && !seeded_reg[idx] |-> direction == DIR_MID)
        else $error("first sample of an axis not mid");

    a_seed_set: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.update && ctrl.is_cal |=> seeded_reg[$past(idx)])
        else $error("updated axis not marked seeded");

    a_bounds_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.update && ctrl.is_cal |=> min_reg[$past(idx)] <= max_reg[$past(idx)])
        else $error("axis min above max after update");

endmodule

// ===== rtl/joystick_axis_auto_range_classifier.sv =====
// Top level: joystick axis direction classifier with self-seeding range tracking.
//
//  channel | dir | ports                     | contents
//  --------+-----+---------------------------+------------------------------------------
//  input   | in  | s_tvalid/s_tready/s_tdata | one request: axis, raw position, hat state
//          |     | s_tuser                   | axis_index
//  result  | out | m_tvalid/m_tready/m_tdata | direction (0 low, 1 mid, 2 high)
//
//  Request register, then result register; one request per cycle sustained while the
//  result is taken, set by the read-modify-write of the per-axis min/max store.
//  Reset (aresetn low, synchronous) empties both stages and clears the seeded flags;
//  the min/max store itself is not reset and is read only once seeded.
//  A stalled result holds the request stage; a new request is still taken whenever
//  the result register moves on or the request stage is empty.
module joystick_axis_auto_range_classifier
    import jarc_pkg::*;
#(
    parameter int NUM_CAL_AXES = DEF_NUM_CAL_AXES,
    parameter int POS_WIDTH    = DEF_POS_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] raw_position, [16] hat_centered, [32:17] hat_angle, [39:33] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [3:0] axis_index
    input  logic [S_TUSER_W-1:0]  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] direction, [7:2] zero
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // Request stage
    logic                  s1_valid_reg;
    logic [AXIS_IDX_W-1:0] s1_axis_reg;
    logic [RAW_W-1:0]      s1_raw_reg;
    logic                  s1_cent_reg;
    logic [ANGLE_W-1:0]    s1_angle_reg;

    // Result stage
    logic                  m_valid_reg;
    dir_t                  m_dir_reg;
    dir_t                  m_dir_next;

    logic                  out_ready, advance, s_fire;
    logic                  is_valid, is_cal, is_vert;
    trk_ctrl_t             trk_ctrl;
    dir_t                  trk_dir, hat_dir;

    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = s1_valid_reg && out_ready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;

    // Axis decode: analog first, then the vertical hat index, the rest horizontal
    assign is_valid = s1_axis_reg < NUM_AXES;
    assign is_cal   = is_valid && (s1_axis_reg < NUM_CAL_AXES);
    assign is_vert  = s1_axis_reg == HAT_VERTICAL_INDEX;

    assign trk_ctrl.update     = advance;
    assign trk_ctrl.is_cal     = is_cal;
    assign trk_ctrl.axis_index = s1_axis_reg;

    jarc_range_trk #(
        .NUM_CAL_AXES (NUM_CAL_AXES),
        .POS_WIDTH    (POS_WIDTH)
    ) u_trk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (trk_ctrl),
        .pos       (POS_WIDTH'(s1_raw_reg)),
        .direction (trk_dir)
    );

    jarc_hat_cls u_hat (
        .vertical     (is_vert),
        .hat_centered (s1_cent_reg),
        .hat_angle    (s1_angle_reg),
        .direction    (hat_dir)
    );

    // Invalid axes answer mid and leave the store alone
    always_comb begin
        m_dir_next = DIR_MID;
        if (is_cal)        m_dir_next = trk_dir;
        else if (is_valid) m_dir_next = hat_dir;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready)  s1_valid_reg <= s_tvalid;
            if (out_ready) m_valid_reg  <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_axis_reg  <= s_tuser[AXIS_IDX_W-1:0];
            s1_raw_reg   <= s_tdata[RAW_W-1:0];
            s1_cent_reg  <= s_tdata[RAW_W];
            s1_angle_reg <= s_tdata[RAW_W+ANGLE_W:RAW_W+1];
        end
        if (advance) begin
            m_dir_reg <= m_dir_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W-2)'(0), m_dir_reg};

    a_invalid_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !is_valid |=> m_tvalid && m_tdata[1:0] == DIR_MID)
        else $error("invalid axis did not answer mid");

    a_centred_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_valid && !is_cal && s1_cent_reg |=> m_tvalid && m_tdata[1:0] == DIR_MID)
        else $error("centred hat did not answer mid");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_ready |=> s1_valid_reg && $stable(s1_axis_reg)
            && $stable(s1_raw_reg) && $stable(s1_angle_reg))
        else $error("stalled request stage lost its request");

endmodule

// ===== bench/jarc_checker.sv =====
// Checker for the axis classifier: watches both channels, predicts directions and compares.
module jarc_checker
    import jarc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   pending,
    output int                   checked
);

    localparam int CAL_AXES = DEF_NUM_CAL_AXES;

    // Hat bounds in whole degrees
    localparam int HX_HIGH_FROM_DEG = 19;
    localparam int HX_HIGH_TO_DEG   = 161;
    localparam int HX_LOW_FROM_DEG  = 198;
    localparam int HX_LOW_TO_DEG    = 342;
    localparam int VY_HIGH_FROM_DEG = 109;
    localparam int VY_HIGH_TO_DEG   = 251;
    localparam int VY_LOW_UPTO_DEG  = 72;
    localparam int VY_LOW_FROM_DEG  = 288;
    localparam int REPORT_LIMIT     = 10;

    logic [RAW_W-1:0] range_lo [CAL_AXES];
    logic [RAW_W-1:0] range_hi [CAL_AXES];
    logic             seeded   [CAL_AXES];
    dir_t             dir_queue[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    function automatic dir_t hat_dir(input logic [ANGLE_W-1:0] angle, input bit vertical);
        int deg;
        deg = (int'(angle) / 100) % 360;
        if (vertical) begin
            if (deg >= VY_HIGH_FROM_DEG && deg <= VY_HIGH_TO_DEG) return DIR_HIGH;
            if (deg <= VY_LOW_UPTO_DEG || deg >= VY_LOW_FROM_DEG) return DIR_LOW;
        end else begin
            if (deg >= HX_HIGH_FROM_DEG && deg <= HX_HIGH_TO_DEG) return DIR_HIGH;
            if (deg >= HX_LOW_FROM_DEG && deg <= HX_LOW_TO_DEG) return DIR_LOW;
        end
        return DIR_MID;
    endfunction

    // Updates the running range of one analog axis and classifies the sample
    function automatic dir_t track_axis(input int idx, input logic [RAW_W-1:0] pos);
        int centre;
        int band;
        if (!seeded[idx]) begin
            range_lo[idx] = pos;
            range_hi[idx] = pos;
            seeded[idx]   = 1'b1;
            return DIR_MID;
        end
        if (pos < range_lo[idx]) range_lo[idx] = pos;
        if (pos > range_hi[idx]) range_hi[idx] = pos;
        centre = (int'(range_lo[idx]) + int'(range_hi[idx])) / 2;
        band   = (int'(range_hi[idx]) - centre) / 3;
        if (int'(pos) < centre - band) return DIR_LOW;
        if (int'(pos) > centre + band) return DIR_HIGH;
        return DIR_MID;
    endfunction

    always @(posedge aclk) begin
        logic [AXIS_IDX_W-1:0] axis;
        logic [RAW_W-1:0]      pos;
        logic                  centred;
        logic [ANGLE_W-1:0]    angle;
        dir_t                  want;
        if (!aresetn) begin
            for (int i = 0; i < CAL_AXES; i++) seeded[i] = 1'b0;
            dir_queue.delete();
        end else begin
            // results first, so a stray result never meets this cycle's request
            if (m_tvalid && m_tready) begin
                checked++;
                if (dir_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: direction %0d, nothing outstanding",
                                 m_tdata[1:0]);
                end else begin
                    want = dir_queue.pop_front();
                    if (m_tdata[1:0] !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("direction mismatch: expected %0d (%s), got %0d",
                                     want, want.name(), m_tdata[1:0]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                axis    = s_tuser;
                pos     = s_tdata[RAW_W-1:0];
                centred = s_tdata[RAW_W];
                angle   = s_tdata[RAW_W+1 +: ANGLE_W];
                want    = DIR_MID;
                if (axis < NUM_AXES) begin
                    if (axis < CAL_AXES)
                        want = track_axis(int'(axis), pos);
                    else if (!centred)
                        want = hat_dir(angle, axis == HAT_VERTICAL_INDEX);
                end
                dir_queue.push_back(want);
            end
        end
        pending = dir_queue.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: clock, reset, request stimulus, result back-pressure and the verdict.
module tb_top;
    import jarc_pkg::*;

    localparam logic [AXIS_IDX_W-1:0] HAT_HORIZONTAL_INDEX = 4'd6;
    localparam logic [AXIS_IDX_W-1:0] NARROW_AXIS          = 4'd3;
    localparam logic [AXIS_IDX_W-1:0] LAST_AXIS_INDEX      = 4'd15;
    localparam int                    CAL_AXES             = DEF_NUM_CAL_AXES;
    localparam int                    IDLE_PERCENT         = 11;

    // Hat sector edges, used to aim random angles at the boundaries
    localparam logic [7:0][ANGLE_W-1:0] HAT_EDGES = {
        HX_HIGH_MIN, HX_HIGH_MAX, HX_LOW_MIN, HX_LOW_MAX,
        HY_HIGH_MIN, HY_HIGH_MAX, HY_LOW_TOP, HY_LOW_BOT
    };

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int  fail_count;
    int  pending;
    int  checked;
    int  sent_count = 0;
    bit  gaps_on    = 1'b0;   // random idling on both sides
    // set at the edge where a request is taken; read at the following falling edge
    logic s_req_taken = 1'b0;

    joystick_axis_auto_range_classifier i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    jarc_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        s_req_taken <= aresetn && s_tvalid && s_tready;
    end

    // Result side: stalls at random, IDLE_PERCENT percent of the time, while gaps are on
    always @(negedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Presents one request from a falling edge and returns at the falling edge after it
    // has been taken. Any idle cycles come first, with tvalid low.
    task automatic send_req(input logic [AXIS_IDX_W-1:0] axis, input logic [RAW_W-1:0] pos,
                            input logic centred, input logic [ANGLE_W-1:0] angle);
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= axis;
        // [15:0] raw_position, [16] hat_centered, [32:17] hat_angle, [39:33] zero
        s_tdata  <= {7'd0, angle, centred, pos};
        do @(negedge aclk); while (!s_req_taken);
        sent_count++;
    endtask

    // Random requests: mostly analog axes, where the range tracking lives, the rest
    // split between the two hat axes and invalid indices.
    task automatic run_random(input int count);
        int                    pick;
        logic [AXIS_IDX_W-1:0] axis;
        logic [RAW_W-1:0]      pos;
        logic [ANGLE_W-1:0]    angle;
        logic                  centred;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 60)      axis = AXIS_IDX_W'($urandom_range(CAL_AXES - 1));
            else if (pick < 75) axis = HAT_HORIZONTAL_INDEX;
            else if (pick < 90) axis = HAT_VERTICAL_INDEX;
            else                axis = AXIS_IDX_W'($urandom_range(LAST_AXIS_INDEX, NUM_AXES));

            // one axis stays in a narrow window so its band is only a few counts wide
            pick = $urandom_range(99);
            if (axis == NARROW_AXIS) pos = 16'd32700 + 16'($urandom_range(100));
            else if (pick < 25)      pos = 16'($urandom_range(255));
            else if (pick < 50)      pos = 16'hFFFF - 16'($urandom_range(255));
            else                     pos = 16'($urandom);

            // aim near sector edges, else anywhere, sometimes past a full turn
            pick = $urandom_range(99);
            if (pick < 40)      angle = HAT_EDGES[3'($urandom_range(7))] - 16'd1
                                        + 16'($urandom_range(2));
            else if (pick < 85) angle = 16'($urandom_range(35999));
            else                angle = 16'($urandom);

            centred = ($urandom_range(99) < 20);
            send_req(axis, pos, centred, angle);
        end
    endtask

    initial begin
        int directed;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests, back to back.
        // Invalid axes answer mid; the first has every position, centred and angle bit set.
        send_req(NUM_AXES, 16'hFFFF, 1'b1, 16'hFFFF);
        send_req(LAST_AXIS_INDEX, 16'h0000, 1'b0, 16'd9000);
        // First sample of an axis seeds it and answers mid; later ones outside it widen the range.
        send_req(4'd0, 16'd0, 1'b0, 16'd0);
        send_req(4'd0, 16'hFFFF, 1'b0, 16'd0);
        send_req(4'd0, 16'd0, 1'b0, 16'd0);
        send_req(4'd0, 16'd32767, 1'b0, 16'd0);
        send_req(4'd5, 16'hFFFF, 1'b0, 16'd0);
        // narrow range on axis 1: band collapses to zero
        send_req(4'd1, 16'd1000, 1'b0, 16'd0);
        send_req(4'd1, 16'd1003, 1'b0, 16'd0);
        send_req(4'd1, 16'd1001, 1'b0, 16'd0);
        send_req(4'd1, 16'd1002, 1'b0, 16'd0);
        // Horizontal hat: centred hat answers mid, then the sector edges and wrap.
        send_req(HAT_HORIZONTAL_INDEX, 16'd0, 1'b1, 16'd9000);
        send_req(HAT_HORIZONTAL_INDEX, 16'd0, 1'b0, 16'd1899);
        send_req(HAT_HORIZONTAL_INDEX, 16'd0, 1'b0, HX_HIGH_MIN);
        send_req(HAT_HORIZONTAL_INDEX, 16'd0, 1'b0, HX_HIGH_MAX + 16'd1);
        send_req(HAT_HORIZONTAL_INDEX, 16'd0, 1'b0, HX_LOW_MIN);
        send_req(HAT_HORIZONTAL_INDEX, 16'd0, 1'b0, HX_LOW_MAX + 16'd1);
        send_req(HAT_HORIZONTAL_INDEX, 16'd0, 1'b0, ANGLE_WRAP + HX_HIGH_MIN);
        send_req(HAT_HORIZONTAL_INDEX, 16'd0, 1'b0, 16'hFFFF);
        // Vertical hat: both low sectors, high sector edges, centred.
        send_req(HAT_VERTICAL_INDEX, 16'd0, 1'b0, 16'd0);
        send_req(HAT_VERTICAL_INDEX, 16'd0, 1'b0, HY_LOW_TOP + 16'd1);
        send_req(HAT_VERTICAL_INDEX, 16'd0, 1'b0, HY_HIGH_MIN);
        send_req(HAT_VERTICAL_INDEX, 16'd0, 1'b0, HY_HIGH_MAX);
        send_req(HAT_VERTICAL_INDEX, 16'd0, 1'b0, 16'd35999);
        send_req(HAT_VERTICAL_INDEX, 16'd0, 1'b1, 16'd0);
        directed = sent_count;

        // Random phases: gaps on, then a flat-out stretch, then gaps again.
        gaps_on = 1'b1;
        run_random(700);

        // hold off until the pipeline has drained completely
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        @(negedge aclk);

        gaps_on = 1'b0;
        run_random(300);
        gaps_on = 1'b1;
        run_random(600);

        s_tvalid <= 1'b0;
        gaps_on = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Sent %0d requests (%0d directed) over analog, hat and invalid axes,",
                 sent_count, directed);
        $display("with random idling on both sides; %0d results compared, %0d failures.",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/jarc_pkg.sv
rtl/jarc_hat_cls.sv
rtl/jarc_range_trk.sv
rtl/joystick_axis_auto_range_classifier.sv
bench/jarc_checker.sv
bench/tb_top.sv
